// ===== design/anc_pkg.sv =====
// Shared constants and action codes for the address-to-name cache.
package anc_pkg;

	localparam int KEY_W      = 32;
	localparam int NAME_W     = 32;
	localparam int COUNT_W    = 11;
	localparam int ACTION_W   = 2;
	localparam int CAPACITY_D = 1024;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

endpackage

// ===== design/anc_store.sv =====
// Key and name storage: one write port and one registered read port.
module anc_store import anc_pkg::*; #(
	parameter int DEPTH = CAPACITY_D,
	parameter int AW    = $clog2(CAPACITY_D)
) (
	input  logic              clk,
	input  logic              wr_key_en,
	input  logic              wr_name_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [KEY_W-1:0]  wr_key,
	input  logic [NAME_W-1:0] wr_name,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [KEY_W-1:0]  rd_key,
	output logic [NAME_W-1:0] rd_name
);

	logic [KEY_W-1:0]  key_mem  [DEPTH];
	logic [NAME_W-1:0] name_mem [DEPTH];
	logic [KEY_W-1:0]  rd_key_q;
	logic [NAME_W-1:0] rd_name_q;

	always_ff @(posedge clk) begin
		if (wr_key_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (wr_name_en) begin
			name_mem[wr_addr] <= wr_name;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q  <= key_mem[rd_addr];
			rd_name_q <= name_mem[rd_addr];
		end
	end

	assign rd_key  = rd_key_q;
	assign rd_name = rd_name_q;

endmodule

// ===== design/address_name_cache_fifo.sv =====
// Fully associative address-to-name cache with linear scan and FIFO replacement.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  action, address_key, key_present,
//                                             name_handle, name_present, name_is_negative
//  rsp      out        rsp_valid / rsp_ready  hit, found_name, entry_count
//
// Flow: a clear, a dropped insert, a keyless lookup or an unused action goes from idle straight
// to the final state, and its result is loaded into the output register once that is free.
// A scanning request walks the F filled entries, F the fill count (at most CAPACITY),
// through the single read port, one entry a cycle, and then goes to the final state.
// A scan stops early at the first matching entry.
// Reset clears the fill count, the overwrite pointer and all control state; the stores
// are not cleared, since only entries below the fill count are ever read.
// One request is worked at a time; req_ready is high in idle even while a result waits
// in the output register, and the next result holds until that one is taken.
module address_name_cache_fifo import anc_pkg::*; #(
	parameter int CAPACITY = CAPACITY_D
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [ACTION_W-1:0] action,
	input  logic [KEY_W-1:0]    address_key,
	input  logic                key_present,
	input  logic [NAME_W-1:0]   name_handle,
	input  logic                name_present,
	input  logic                name_is_negative,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic                hit,
	output logic [NAME_W-1:0]   found_name,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int FW = $clog2(CAPACITY + 1);
	localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);
	localparam logic [AW-1:0] PTR_LAST = AW'(CAPACITY - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]          st_q;
	logic [KEY_W-1:0]    key_q;
	logic [NAME_W-1:0]   name_q;
	logic                ins_q;
	logic                res_hit_q;
	logic [NAME_W-1:0]   res_name_q;
	logic [FW-1:0]       fill_q;
	logic [AW-1:0]       ptr_q;
	logic [FW-1:0]       rd_cnt_q;
	logic                pend_s1;
	logic [AW-1:0]       idx_s1;
	logic                rsp_valid_q;
	logic                hit_q;
	logic [NAME_W-1:0]   found_name_q;
	logic [COUNT_W-1:0]  entry_count_q;

	logic                req_xfer;
	logic                do_insert;
	logic                do_scan;
	logic                issue;
	logic                match;
	logic                scan_done;
	logic                full;
	logic                wr_key_en;
	logic                wr_name_en;
	logic [AW-1:0]       wr_addr;
	logic [KEY_W-1:0]    rd_key;
	logic [NAME_W-1:0]   rd_name;
	logic [FW+COUNT_W-1:0] fill_ext;

	assign req_ready = (st_q == ST_IDLE);
	assign req_xfer  = req_valid && req_ready;

	// Decide at transfer whether the request needs a table scan.
	assign do_insert = (action == ACT_INSERT) && key_present && name_present
		&& !name_is_negative;
	assign do_scan   = do_insert || ((action == ACT_LOOKUP) && key_present);

	assign full      = (fill_q == CAP_F);
	assign issue     = (st_q == ST_SCAN) && (rd_cnt_q < fill_q);
	assign match     = (st_q == ST_SCAN) && pend_s1 && (rd_key == key_q);
	assign scan_done = (st_q == ST_SCAN) && !pend_s1 && !(rd_cnt_q < fill_q);

	// Store writes: overwrite the name on a key match, otherwise place a new entry
	// at the next free slot or, once full, at the overwrite pointer.
	always_comb begin
		wr_key_en  = 1'b0;
		wr_name_en = 1'b0;
		wr_addr    = idx_s1;
		if (match && ins_q) begin
			wr_name_en = 1'b1;
		end else if (scan_done && ins_q) begin
			wr_key_en  = 1'b1;
			wr_name_en = 1'b1;
			wr_addr    = full ? ptr_q : fill_q[AW-1:0];
		end
	end

	anc_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk        (clk),
		.wr_key_en  (wr_key_en),
		.wr_name_en (wr_name_en),
		.wr_addr    (wr_addr),
		.wr_key     (key_q),
		.wr_name    (name_q),
		.rd_en      (issue),
		.rd_addr    (rd_cnt_q[AW-1:0]),
		.rd_key     (rd_key),
		.rd_name    (rd_name)
	);

	// Sequencer: take a request, walk the filled entries, then post the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			fill_q   <= '0;
			ptr_q    <= '0;
			rd_cnt_q <= '0;
			pend_s1  <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (req_xfer) begin
						rd_cnt_q <= '0;
						pend_s1  <= 1'b0;
						if (action == ACT_CLEAR) begin
							fill_q <= '0;
							ptr_q  <= '0;
						end
						st_q <= do_scan ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					// Advance the read address; data for it lands next cycle.
					// Drop any read still in flight once a match ends the scan.
					pend_s1 <= issue && !match;
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (match) begin
						st_q <= ST_FIN;
					end else if (scan_done) begin
						if (ins_q) begin
							if (full) begin
								ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
							end else begin
								fill_q <= fill_q + 1'b1;
							end
						end
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Hold until the output register is free.
					if (!rsp_valid_q || rsp_ready) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload and scan results.
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= rd_cnt_q[AW-1:0];
		end
		if (req_xfer) begin
			key_q      <= address_key;
			name_q     <= name_handle;
			ins_q      <= (action == ACT_INSERT);
			res_hit_q  <= 1'b0;
			res_name_q <= '0;
		end else if (match) begin
			res_hit_q <= 1'b1;
			if (!ins_q) begin
				res_name_q <= rd_name;
			end
		end
	end

	assign fill_ext = {{COUNT_W{1'b0}}, fill_q};

	// Output register: load on leaving the final state, drop once transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((st_q == ST_FIN) && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_FIN) && (!rsp_valid_q || rsp_ready)) begin
			hit_q         <= res_hit_q;
			found_name_q  <= res_name_q;
			entry_count_q <= fill_ext[COUNT_W-1:0];
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign found_name  = found_name_q;
	assign entry_count = entry_count_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CAP_F)
		else $error("fill count above capacity");

	a_ptr_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q != '0) |-> full)
		else $error("overwrite pointer moved before table filled");

	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_key_en || wr_name_en) |-> (st_q == ST_SCAN))
		else $error("store write outside scan");

	a_pend_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(st_q == ST_SCAN))
		else $error("read data pending without a scan");
`endif

endmodule
